// ===== hw/rtl/spq_pkg.sv =====
// spq_pkg: shared types and codes for the sorted priority queue
// used by spq_cell and sorted_priority_queue_core; depends on nothing
package spq_pkg;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic do_insert;
    logic do_remove;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// spq_cell: one slot of the sorted chain, holds a priority and a value
// depends on spq_pkg for the broadcast control struct
module spq_cell #(
  parameter int PRIORITY_BITS = 8
) (
  input  logic                     clk,
  input  spq_pkg::cell_ctrl_t      ctrl,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic [31:0]              new_value,
  input  logic                     occupied,
  input  logic                     left_stays,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic [31:0]              left_value,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  input  logic [31:0]              right_value,
  output logic                     stays,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic [31:0]              value
);

  logic [PRIORITY_BITS-1:0] prio_next;
  logic [31:0]              value_next;

  // equal priority stays ahead of the new entry, which keeps fifo order
  assign stays = occupied && (prio >= new_prio);

  always_comb begin
    prio_next  = prio;
    value_next = value;
    if (ctrl.do_insert && !stays) begin
      if (left_stays) begin
        prio_next  = new_prio;
        value_next = new_value;
      end else begin
        prio_next  = left_prio;
        value_next = left_value;
      end
    end else if (ctrl.do_remove) begin
      prio_next  = right_prio;
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    prio  <= prio_next;
    value <= value_next;
  end

endmodule

// ===== hw/rtl/sorted_priority_queue_core.sv =====
// sorted_priority_queue_core: bounded priority queue as a chain of compare-and-shift cells
// depends on spq_pkg and spq_cell
//
//  channel | valid    | stall     | payload
//  --------+----------+-----------+-------------------------------------
//  in      | in_valid | in_stall  | cmd, item_value, item_priority
//  out     | out_valid| out_stall | out_value, status, occupancy
//
// one request per cycle while in_stall is low: every cell compares against the new priority in
// parallel and shifts toward its neighbor in the same cycle
// the result of a request appears on out in the cycle after it is accepted
// a new request is taken while the held result is taken in the same cycle
// rst (synchronous) empties the queue and drops any held result
module sorted_priority_queue_core #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [31:0] item_value,
  input  logic [7:0]  item_priority,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic [1:0]  status,
  output logic [4:0]  occupancy
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic                     accept;
  logic                     is_insert;
  logic                     is_full;
  logic                     is_empty;
  logic [PRIORITY_BITS+7:0] prio_wide;
  logic [PRIORITY_BITS-1:0] new_prio;
  spq_pkg::cell_ctrl_t      ctrl;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W+4:0] count_wide;

  logic                     stays_w  [CAPACITY];
  logic [PRIORITY_BITS-1:0] prio_w   [CAPACITY];
  logic [31:0]              value_w  [CAPACITY];

  logic [1:0]  status_next;
  logic [31:0] out_value_next;

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign is_insert = (spq_pkg::cmd_t'(cmd) == spq_pkg::CMD_INSERT);
  assign is_full   = (count == CAP_CNT);
  assign is_empty  = (count == '0);

  // keep only the low PRIORITY_BITS bits of the priority
  assign prio_wide = {{PRIORITY_BITS{1'b0}}, item_priority};
  assign new_prio  = prio_wide[PRIORITY_BITS-1:0];

  assign ctrl.do_insert = accept && is_insert && !is_full;
  assign ctrl.do_remove = accept && !is_insert && !is_empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic                     occupied;
    logic                     left_stays;
    logic [PRIORITY_BITS-1:0] left_prio;
    logic [31:0]              left_value;
    logic [PRIORITY_BITS-1:0] right_prio;
    logic [31:0]              right_value;

    assign occupied = (IDX < count);

    if (i == 0) begin : g_head
      assign left_stays = 1'b1;
      assign left_prio  = new_prio;
      assign left_value = item_value;
    end else begin : g_body
      assign left_stays = stays_w[i-1];
      assign left_prio  = prio_w[i-1];
      assign left_value = value_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_prio  = '0;
      assign right_value = '0;
    end else begin : g_inner
      assign right_prio  = prio_w[i+1];
      assign right_value = value_w[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_prio   (new_prio),
      .new_value  (item_value),
      .occupied   (occupied),
      .left_stays (left_stays),
      .left_prio  (left_prio),
      .left_value (left_value),
      .right_prio (right_prio),
      .right_value(right_value),
      .stays      (stays_w[i]),
      .prio       (prio_w[i]),
      .value      (value_w[i])
    );
  end

  always_comb begin
    count_next     = count;
    out_value_next = '0;
    if (is_insert) begin
      if (is_full) begin
        status_next = spq_pkg::ST_FULL;
      end else begin
        status_next = spq_pkg::ST_INSERTED;
        count_next  = count + 1'b1;
      end
    end else begin
      if (is_empty) begin
        status_next = spq_pkg::ST_EMPTY;
      end else begin
        status_next    = spq_pkg::ST_REMOVED;
        out_value_next = value_w[0];
        count_next     = count - 1'b1;
      end
    end
  end

  assign count_wide = {5'b0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value <= out_value_next;
      status    <= status_next;
      occupancy <= count_wide[4:0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("queue count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && is_insert && !is_full |=> count == CNT_W'($past(count) + 1'b1))
    else $error("insert did not add an entry");

  a_remove_empty: assert property (@(posedge clk) disable iff (rst)
    accept && !is_insert && is_empty |=>
      out_valid && status == spq_pkg::ST_EMPTY && out_value == '0 && count == '0)
    else $error("remove on empty reported wrongly");

  a_remove_head: assert property (@(posedge clk) disable iff (rst)
    accept && !is_insert && !is_empty |=> out_value == $past(value_w[0]))
    else $error("remove did not return the head value");

endmodule
